// ===== rtl/ghq_pkg.sv =====
// shared types and constants of the hang-in/hang-out qualifier
package ghq_pkg;

  localparam int CH_W        = 4;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CNT_W       = 17;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;
  localparam int MAX_CH      = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [0:0] {
    REG_HANG_IN  = 1'b0,
    REG_HANG_OUT = 1'b1
  } cfg_reg_t;

  // classified observation handed from front to back
  typedef struct packed {
    logic              in_range;
    logic [CH_W-1:0]   channel;
    logic              detected;
    logic [TIME_W-1:0] now_ms;
  } ghq_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] event_duration_ms;
    logic [TIME_W-1:0] event_start_ms;
    logic              finished;
    logic              started;
  } ghq_result_t;

  localparam int RESULT_W = $bits(ghq_result_t);

endpackage

// ===== rtl/gesture_hang_in_hang_out_qualifier_core.sv =====
// Hang-in/hang-out gesture qualifier: each observation names a channel, a raw detected
// bit and a millisecond time, and yields exactly one result transaction. A channel
// reports started after hang_in+1 consecutive detections and finished (with start
// time and modular duration) after hang_out+1 consecutive losses once started. The
// block takes one observation per clock unless the output stalls; the rate is set by
// the back end, which does one read-modify-write of the channel table per observation.
// A result passes through the two-entry queue and then the output register, and the
// queue keeps the input ready while a result waits until both its entries are full.
// Reset clears every channel's active flag at once, so no clearing pass follows it.
// Channels at or above NUM_CHANNELS change nothing and return an all-zero result.
module gesture_hang_in_hang_out_qualifier_core #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // channel[3:0], detected[4], now_ms[36:5], zero pad
  input  logic [ghq_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // started[0], finished[1], event_start_ms[33:2], event_duration_ms[65:34], zero pad
  output logic [ghq_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [ghq_pkg::CFG_W-1:0]       cfg_wdata
);
  import ghq_pkg::*;

  logic [CFG_W-1:0] hang_in_r, hang_out_r;
  ghq_item_t        front_item, queue_item;
  logic             q_full, q_not_empty, q_pop, q_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hang_in_r  <= '0;
      hang_out_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HANG_IN:  hang_in_r  <= cfg_wdata;
        REG_HANG_OUT: hang_out_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  ghq_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .in_tdata (in_tdata),
    .item     (front_item)
  );

  ghq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (queue_item)
  );

  ghq_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .hang_in    (hang_in_r),
    .hang_out   (hang_out_r),
    .item_valid (q_not_empty),
    .item       (queue_item),
    .item_pop   (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/ghq_front.sv =====
// front end: unpacks an observation and checks its channel against the table size
module ghq_front #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic [ghq_pkg::IN_TDATA_W-1:0] in_tdata,
  output ghq_pkg::ghq_item_t             item
);
  import ghq_pkg::*;

  logic [CH_W-1:0] channel;

  assign channel = in_tdata[CH_W-1:0];

  always_comb begin
    item.channel  = channel;
    item.detected = in_tdata[CH_W];
    item.now_ms   = in_tdata[CH_W+1 +: TIME_W];
    item.in_range = (int'(channel) < NUM_CHANNELS);
  end

endmodule

// ===== rtl/ghq_queue.sv =====
// two-entry queue between the front end and the back end
module ghq_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ghq_pkg::ghq_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output ghq_pkg::ghq_item_t pop_item
);
  import ghq_pkg::*;

  ghq_item_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    priority if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/ghq_back.sv =====
// back end: per-channel table read-modify-write and the output register
module ghq_back #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [ghq_pkg::CFG_W-1:0]       hang_in,
  input  logic [ghq_pkg::CFG_W-1:0]       hang_out,
  input  logic                            item_valid,
  input  ghq_pkg::ghq_item_t              item,
  output logic                            item_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ghq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ghq_pkg::*;

  localparam int DEPTH = (NUM_CHANNELS < MAX_CH) ? NUM_CHANNELS : MAX_CH;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DEPTH-1:0]  active_r;
  logic [CNT_W-1:0]  hold_r    [DEPTH];
  logic [CNT_W-1:0]  release_r [DEPTH];
  logic [TIME_W-1:0] begin_r   [DEPTH];
  logic [TIME_W-1:0] end_r     [DEPTH];

  logic              out_valid_r, out_valid_nxt;
  ghq_result_t       out_data_r;

  logic [IDX_W-1:0]  idx;
  logic              wr_en;
  logic              act_cur;
  logic [CNT_W-1:0]  hold_cur, rel_cur;
  logic [CNT_W-1:0]  hin_ext, hout_ext, hold_lim, rel_lim, hold_inc, rel_inc;
  logic              act_nxt;
  logic [CNT_W-1:0]  hold_nxt, rel_nxt;
  logic [TIME_W-1:0] begin_nxt, end_nxt;
  ghq_result_t       res;

  assign item_pop = item_valid && (!out_valid_r || out_tready);
  assign idx      = item.channel[IDX_W-1:0];
  assign wr_en    = item_pop && item.in_range;

  assign hin_ext  = {1'b0, hang_in};
  assign hout_ext = {1'b0, hang_out};
  assign hold_lim = hin_ext + 1'b1;
  assign rel_lim  = hout_ext + 1'b1;

  always_comb begin
    act_cur   = active_r[idx];
    hold_cur  = hold_r[idx];
    rel_cur   = release_r[idx];
    begin_nxt = begin_r[idx];
    end_nxt   = end_r[idx];
    act_nxt   = act_cur;
    hold_nxt  = hold_cur;
    rel_nxt   = rel_cur;
    hold_inc  = '0;
    rel_inc   = '0;
    res       = '0;
    if (item.in_range) begin
      if (item.detected) begin
        // a fresh detection opens the gesture at this time
        if (!act_cur) begin
          begin_nxt = item.now_ms;
          hold_cur  = '0;
        end
        act_nxt     = 1'b1;
        res.started = (hold_cur == hin_ext);
        hold_inc    = hold_cur + 1'b1;
        hold_nxt    = (hold_inc > hold_lim) ? hold_lim : hold_inc;
        rel_nxt     = '0;
      end else if (act_cur) begin
        if (hold_cur <= hin_ext) begin
          act_nxt = 1'b0;
        end else begin
          if (rel_cur == '0) begin
            end_nxt = item.now_ms;
          end
          if (rel_cur == hout_ext) begin
            act_nxt                 = 1'b0;
            res.finished            = 1'b1;
            res.event_start_ms      = begin_nxt;
            res.event_duration_ms   = end_nxt - begin_nxt;
          end
          rel_inc = rel_cur + 1'b1;
          rel_nxt = (rel_inc > rel_lim) ? rel_lim : rel_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (wr_en) begin
      active_r[idx] <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hold_r[idx]    <= hold_nxt;
      release_r[idx] <= rel_nxt;
      begin_r[idx]   <= begin_nxt;
      end_r[idx]     <= end_nxt;
    end
  end

  always_comb begin
    priority if (item_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), out_data_r};

endmodule

// ===== rtl/ghq_checker.sv =====
// port-level checks of the qualifier, bound to the top level
module ghq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic [ghq_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready
);

  // a result never both confirms and ends a gesture
  a_start_xor_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("started and finished set in one result");

  // event fields are zero unless the transaction ends a gesture
  a_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[1]) |-> (out_tdata[65:2] == '0))
    else $error("event fields nonzero without finished");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("result changed while stalled");

endmodule

bind gesture_hang_in_hang_out_qualifier_core ghq_checker u_ghq_checker (.*);
